/* rtl/rc4_pkg.sv */
package rc4_pkg;

  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KLEN_W = 9;
  localparam logic [KLEN_W-1:0] KEY_DEPTH_LEN = KLEN_W'(KEY_DEPTH);
  localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = 9'd16;
  localparam int PERM_SIZE = 256;
  localparam logic [7:0] PERM_LAST = 8'(PERM_SIZE - 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCHED = 2'd1,
    OP_ENC   = 2'd2
  } rc4_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCH_INIT,
    ST_SCH_RD,
    ST_SCH_J,
    ST_SCH_WK,
    ST_SCH_WJ,
    ST_ENC_J,
    ST_ENC_SWAP,
    ST_ENC_OUT
  } rc4_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_index;
    logic [7:0] byte_in;
    logic       end_of_message;
  } rc4_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last;
  } rc4_out_t;

endpackage

/* rtl/rc4_stream_cipher.sv */
// encrypt: states ST_ENC_J, ST_ENC_SWAP, ST_ENC_OUT; the result is registered in ST_ENC_OUT
//   once the output is free, and the next input is taken back in idle (permutation ram port)
// load key: one byte per cycle
// schedule: ST_SCH_INIT writes 256 entries, then 256 swap steps of RD, J, WK, WJ states
// reset: both indices zero, key_length 16; permutation and key rams are not cleared
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rc4_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rc4_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KLEN_W-1:0] cfg_key_length
);

  logic [7:0]        perm_mem [PERM_SIZE];
  logic [7:0]        key_mem  [KEY_DEPTH];

  rc4_state_t        state_r, state_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [KEY_AW-1:0] kpos_r, kpos_nxt;
  logic [7:0]        i_r, i_nxt;
  logic [7:0]        j_r, j_nxt;
  logic [7:0]        si_r, si_nxt;
  logic [7:0]        sj_r, sj_nxt;
  logic [7:0]        t_r, t_nxt;
  logic              fwd_i_r, fwd_i_nxt;
  logic              fwd_j_r, fwd_j_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              eom_r, eom_nxt;
  rc4_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KLEN_W-1:0] key_length_r;

  logic              perm_we;
  logic [7:0]        perm_waddr;
  logic [7:0]        perm_wdata;
  logic [7:0]        perm_raddr;
  logic [7:0]        perm_rdata_r;
  logic              key_we;
  logic [7:0]        key_rdata_r;
  logic [KLEN_W-1:0] eff_len;
  logic              in_fire;
  logic              out_free;
  logic [7:0]        ks;

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata_r <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[in_data.key_index[KEY_AW-1:0]] <= in_data.byte_in;
    end
    key_rdata_r <= key_mem[kpos_r];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      key_length_r <= cfg_key_length;
    end
  end

  always_comb begin
    if (key_length_r == '0) begin
      eff_len = KLEN_W'(1);
    end else if (key_length_r > KEY_DEPTH_LEN) begin
      eff_len = KEY_DEPTH_LEN;
    end else begin
      eff_len = key_length_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ks        = fwd_j_r ? si_r : (fwd_i_r ? sj_r : perm_rdata_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    kpos_r  <= kpos_nxt;
    si_r    <= si_nxt;
    sj_r    <= sj_nxt;
    t_r     <= t_nxt;
    fwd_i_r <= fwd_i_nxt;
    fwd_j_r <= fwd_j_nxt;
    data_r  <= data_nxt;
    eom_r   <= eom_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kpos_nxt      = kpos_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    fwd_i_nxt     = fwd_i_r;
    fwd_j_nxt     = fwd_j_r;
    data_nxt      = data_r;
    eom_nxt       = eom_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    perm_we       = 1'b0;
    perm_waddr    = cnt_r;
    perm_wdata    = cnt_r;
    perm_raddr    = t_r;
    key_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.opcode)
            OP_LOAD: begin
              key_we = ({1'b0, in_data.key_index} < KEY_DEPTH_LEN);
            end
            OP_SCHED: begin
              cnt_nxt   = '0;
              state_nxt = ST_SCH_INIT;
            end
            OP_ENC: begin
              i_nxt      = i_r + 8'd1;
              perm_raddr = i_r + 8'd1;
              data_nxt   = in_data.byte_in;
              eom_nxt    = in_data.end_of_message;
              state_nxt  = ST_ENC_J;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCH_INIT: begin
        perm_we = 1'b1;
        if (cnt_r == PERM_LAST) begin
          cnt_nxt   = '0;
          kpos_nxt  = '0;
          j_nxt     = '0;
          state_nxt = ST_SCH_RD;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end
      ST_SCH_RD: begin
        perm_raddr = cnt_r;
        state_nxt  = ST_SCH_J;
      end
      ST_SCH_J: begin
        j_nxt      = j_r + perm_rdata_r + key_rdata_r;
        si_nxt     = perm_rdata_r;
        perm_raddr = j_r + perm_rdata_r + key_rdata_r;
        state_nxt  = ST_SCH_WK;
      end
      ST_SCH_WK: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdata_r;
        state_nxt  = ST_SCH_WJ;
      end
      ST_SCH_WJ: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
        if (KLEN_W'(kpos_r) + KLEN_W'(1) == eff_len) begin
          kpos_nxt = '0;
        end else begin
          kpos_nxt = kpos_r + KEY_AW'(1);
        end
        if (cnt_r == PERM_LAST) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 8'd1;
          state_nxt = ST_SCH_RD;
        end
      end
      ST_ENC_J: begin
        si_nxt     = perm_rdata_r;
        j_nxt      = j_r + perm_rdata_r;
        perm_raddr = j_r + perm_rdata_r;
        state_nxt  = ST_ENC_SWAP;
      end
      ST_ENC_SWAP: begin
        sj_nxt     = perm_rdata_r;
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = perm_rdata_r;
        t_nxt      = si_r + perm_rdata_r;
        perm_raddr = si_r + perm_rdata_r;
        fwd_j_nxt  = (si_r + perm_rdata_r == j_r);
        fwd_i_nxt  = (si_r + perm_rdata_r == i_r);
        state_nxt  = ST_ENC_OUT;
      end
      ST_ENC_OUT: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
        if (out_free) begin
          out_nxt.byte_out = data_r ^ ks;
          out_nxt.last     = eom_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_out_from_enc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_ENC_OUT))
    else $error("result raised outside the encrypt output step");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !perm_we)
    else $error("permutation written while idle");

  a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCH_WJ && cnt_r == PERM_LAST) |=>
      (state_r == ST_IDLE && i_r == 8'd0 && j_r == 8'd0))
    else $error("schedule did not clear indices");

  a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENC_OUT && out_valid && !out_ready) |=> (state_r == ST_ENC_OUT))
    else $error("result overwritten while output stalled");
`endif

endmodule

/* dv/rc4_stream_cipher_checker.sv */
`timescale 1ns / 100ps

module rc4_stream_cipher_checker
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  rc4_in_t           in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  rc4_out_t          out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [KLEN_W-1:0] cfg_key_length,
  output int                fail_count,
  output int                outstanding
);

  localparam int MAX_REPORTS = 10;

  logic [7:0]        sbox [PERM_SIZE];
  logic [7:0]        key_mem [KEY_DEPTH];
  logic [7:0]        gen_i;
  logic [7:0]        gen_j;
  logic [KLEN_W-1:0] key_len;
  rc4_out_t          cipher_q [$];
  int                mismatches;

  function automatic void key_schedule();
    int         n;
    logic [7:0] j;
    logic [7:0] t;
    if (key_len == '0)
      n = 1;
    else if (int'(key_len) > KEY_DEPTH)
      n = KEY_DEPTH;
    else
      n = int'(key_len);
    for (int k = 0; k < PERM_SIZE; k++)
      sbox[k] = 8'(k);
    j = '0;
    for (int k = 0; k < PERM_SIZE; k++) begin
      j = j + sbox[k] + key_mem[k % n];
      t = sbox[k];
      sbox[k] = sbox[j];
      sbox[j] = t;
    end
    gen_i = '0;
    gen_j = '0;
  endfunction

  function automatic logic [7:0] keystream_byte();
    logic [7:0] t;
    logic [7:0] sum;
    gen_i = gen_i + 8'd1;
    gen_j = gen_j + sbox[gen_i];
    t = sbox[gen_i];
    sbox[gen_i] = sbox[gen_j];
    sbox[gen_j] = t;
    sum = sbox[gen_i] + sbox[gen_j];
    return sbox[sum];
  endfunction

  always @(posedge clk) begin
    rc4_out_t want;
    if (!rst_n) begin
      gen_i = '0;
      gen_j = '0;
      key_len = KEY_LENGTH_RST;
      cipher_q.delete();
    end else begin
      // result transaction
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: byte_out=%02h last=%b",
                     out_data.byte_out, out_data.last);
        end else begin
          want = cipher_q.pop_front();
          if (out_data.byte_out !== want.byte_out || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result mismatch: expected byte_out=%02h last=%b, ",
                        "got byte_out=%02h last=%b"},
                       want.byte_out, want.last, out_data.byte_out, out_data.last);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        key_len = cfg_key_length;
      if (in_valid && in_ready) begin
        case (in_data.opcode)
          OP_LOAD:  key_mem[in_data.key_index] = in_data.byte_in;
          OP_SCHED: key_schedule();
          OP_ENC: begin
            want.byte_out = in_data.byte_in ^ keystream_byte();
            want.last = in_data.end_of_message;
            cipher_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
    fail_count  <= mismatches;
    outstanding <= cipher_q.size();
  end

endmodule

/* dv/rc4_stream_cipher_tb.sv */
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SCHED_CYCLES = 1300;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASES       = 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  rc4_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  rc4_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [KLEN_W-1:0] cfg_key_length;
  int                fail_count;
  int                outstanding;

  int                items_sent;
  int                squeeze_req;
  bit                tx_calm;
  bit                tx_rush;
  logic              key_written [KEY_DEPTH];
  logic [KLEN_W-1:0] length_plan [PHASES] =
    '{9'd1, 9'd7, 9'd256, 9'd511, 9'd16, 9'd2, 9'd257, 9'd33};

  rc4_stream_cipher DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_key_length(cfg_key_length)
  );

  rc4_stream_cipher_checker cipher_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_key_length(cfg_key_length),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd1();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int used_key_bytes(input logic [KLEN_W-1:0] klen);
    if (klen == '0)
      return 1;
    if (int'(klen) > KEY_DEPTH)
      return KEY_DEPTH;
    return int'(klen);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                           input logic [7:0] data, input logic eom);
    int      gap;
    rc4_in_t item;
    if ($urandom_range(0, 39) == 0)
      tx_calm = !tx_calm;
    gap = (tx_calm || tx_rush) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.opcode = op;
    item.key_index = idx;
    item.byte_in = data;
    item.end_of_message = eom;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD)
      key_written[idx] = 1'b1;
    if (op != OP_UNUSED)
      items_sent++;
  endtask

  task automatic send_message(input int len, input bit terminated);
    for (int b = 1; b <= len; b++)
      send_item(OP_ENC, rnd8(), rnd8(), terminated && b == len);
  endtask

  // every unwritten byte below n, plus random rewrites (inline for n <= 32, appended otherwise)
  task automatic load_key(input int n);
    for (int k = 0; k < n; k++)
      if (!key_written[k] || (n <= 32 && $urandom_range(0, 2) == 0))
        send_item(OP_LOAD, 8'(k), rnd8(), rnd1());
    if (n > 32)
      repeat ($urandom_range(1, 4))
        send_item(OP_LOAD, 8'($urandom_range(0, n - 1)), rnd8(), rnd1());
  endtask

  task automatic write_key_length(input logic [KLEN_W-1:0] value);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SCHED_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_key_length <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver
  initial begin
    int hold;
    int squeeze_seen;
    bit calm;
    hold = 0;
    squeeze_seen = 0;
    calm = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        hold = LONG_HOLD;
      end else if (out_valid && out_ready) begin
        if ($urandom_range(0, 39) == 0)
          calm = !calm;
        hold = calm ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sender
  initial begin
    int                phase_end;
    int                n;
    logic [KLEN_W-1:0] klen;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_key_length = KEY_LENGTH_RST;
    rst_n = 1'b0;
    items_sent = 0;
    squeeze_req = 0;
    tx_calm = 1'b0;
    tx_rush = 1'b0;
    for (int k = 0; k < KEY_DEPTH; k++)
      key_written[k] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero key length acts as one byte
    write_key_length('0);
    send_item(OP_LOAD, 8'h00, 8'hff, 1'b1);
    send_item(OP_LOAD, 8'hff, 8'h00, 1'b0);
    send_item(OP_LOAD, 8'hff, 8'hff, 1'b0);
    send_item(OP_UNUSED, 8'hff, 8'hff, 1'b1);
    send_item(OP_SCHED, 8'h00, 8'h00, 1'b0);
    send_item(OP_ENC, 8'hff, 8'h00, 1'b0);
    send_item(OP_ENC, 8'h00, 8'hff, 1'b0);
    send_item(OP_ENC, 8'h5a, 8'h5a, 1'b1);
    send_item(OP_LOAD, 8'h00, 8'h00, 1'b0);
    send_item(OP_SCHED, 8'hff, 8'hff, 1'b1);
    send_item(OP_ENC, 8'h00, 8'hff, 1'b1);
    send_item(OP_ENC, 8'hff, 8'h00, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      klen = (p == PHASES - 1) ? KLEN_W'($urandom_range(0, 511)) : length_plan[p];
      n = used_key_bytes(klen);
      write_key_length(klen);
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      // back-pressure burst while the receiver holds off
      if (p % 4 == 1) begin
        squeeze_req <= squeeze_req + 1;
        tx_rush = 1'b1;
        send_message(40, 1'b1);
        tx_rush = 1'b0;
      end
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            load_key(n);
            send_item(OP_SCHED, rnd8(), rnd8(), rnd1());
            repeat ($urandom_range(1, 3))
              send_message($urandom_range(1, 24), 1'b1);
          end
          6: send_message($urandom_range(1, 16), 1'b1);
          7: begin
            repeat ($urandom_range(1, 4))
              send_item(OP_UNUSED, rnd8(), rnd8(), rnd1());
            send_item(OP_LOAD, rnd8(), rnd8(), rnd1());
          end
          default: begin
            repeat ($urandom_range(1, 3))
              send_item(OP_LOAD, 8'($urandom_range(0, n - 1)), rnd8(), rnd1());
            send_message($urandom_range(1, 8), 1'b0);
          end
        endcase
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SCHED_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
